[hdl/dnswe_pkg.sv]
// Package for the DNS name wire encoder: field widths, error codes,
// character constants, per-name state and result word types.
// Depends on nothing; every other file of the block uses it.
package dnswe_pkg;

  localparam int unsigned NameMaxBytesDefault  = 255;
  localparam int unsigned LabelMaxBytesDefault = 63;

  localparam int unsigned PosW   = 8;
  localparam int unsigned LenW   = 7;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] CharDash = 8'h2d;
  localparam logic [7:0] CharStar = 8'h2a;
  localparam logic [7:0] CharDot  = 8'h2e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE        = 3'd0,
    ERR_TOO_LONG    = 3'd1,
    ERR_LEADING_DOT = 3'd2,
    ERR_EMPTY_LABEL = 3'd3,
    ERR_BAD_CHAR    = 3'd4,
    ERR_LABEL_LONG  = 3'd5
  } err_e;

  typedef struct packed {
    logic [PosW-1:0] write_pos;
    logic [PosW-1:0] label_start;
    logic [LenW-1:0] label_len;
    logic [LenW-1:0] labels_done;
    logic            error_seen;
  } state_t;

  localparam state_t StateFresh = '{
    write_pos:   8'd1,
    label_start: 8'd0,
    label_len:   7'd0,
    labels_done: 7'd0,
    error_seen:  1'b0
  };

  typedef struct packed {
    logic [PosW-1:0] write_addr;
    logic [7:0]      write_byte;
    logic            write_valid;
    err_e            error_code;
    logic [7:0]      total_length;
    logic [LenW-1:0] label_count;
    logic            done_res;
  } res_t;

  // Everything one character produces: the next state and up to three words.
  typedef struct packed {
    state_t                next;
    res_t [MaxRes-1:0]     res;
    logic [1:0]            count;
  } step_t;

endpackage

[hdl/dnswe_ifs.sv]
// Handshake interfaces of the DNS name wire encoder: character input
// channel and wire-format write output channel. Depends on dnswe_pkg.
interface dnswe_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       final_char;

  modport source (output valid, output char_in, output final_char, input ready);
  modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

interface dnswe_wr_if;
  logic                          valid;
  logic                          ready;
  logic [dnswe_pkg::PosW-1:0]    write_addr;
  logic [7:0]                    write_byte;
  logic                          write_valid;
  logic [dnswe_pkg::ErrW-1:0]    error_code;
  logic [7:0]                    total_length;
  logic [dnswe_pkg::LenW-1:0]    label_count;
  logic                          done_res;

  modport source (output valid, output write_addr, output write_byte, output write_valid,
                  output error_code, output total_length, output label_count,
                  output done_res, input ready);
  modport sink   (input valid, input write_addr, input write_byte, input write_valid,
                  input error_code, input total_length, input label_count,
                  input done_res, output ready);
endinterface

[hdl/dnswe_step.sv]
// Per-character encoding step: checks one character against the current
// name state and yields the next state and up to three write words.
// Depends on dnswe_pkg.
module dnswe_step #(
  parameter int unsigned NAME_MAX_BYTES  = dnswe_pkg::NameMaxBytesDefault,
  parameter int unsigned LABEL_MAX_BYTES = dnswe_pkg::LabelMaxBytesDefault
) (
  input  dnswe_pkg::state_t state_i,
  input  logic [7:0]        char_i,
  input  logic              final_i,
  output dnswe_pkg::step_t  step_o
);

  localparam logic [dnswe_pkg::PosW-1:0] PosLimit = dnswe_pkg::PosW'(NAME_MAX_BYTES - 2);
  localparam logic [dnswe_pkg::LenW-1:0] LenLimit = dnswe_pkg::LenW'(LABEL_MAX_BYTES);

  function automatic dnswe_pkg::res_t make_res(
    input logic [dnswe_pkg::PosW-1:0] addr,
    input logic [7:0]                 data,
    input logic                       wr,
    input dnswe_pkg::err_e            err,
    input logic [7:0]                 total,
    input logic [dnswe_pkg::LenW-1:0] labels,
    input logic                       done
  );
    dnswe_pkg::res_t r;
    r.write_addr   = addr;
    r.write_byte   = data;
    r.write_valid  = wr;
    r.error_code   = err;
    r.total_length = total;
    r.label_count  = labels;
    r.done_res     = done;
    return r;
  endfunction

  logic                         is_dot;
  logic                         is_upper;
  logic                         is_allowed;
  logic [7:0]                   lower_char;
  logic [dnswe_pkg::LenW-1:0]   len_inc;
  logic [dnswe_pkg::LenW-1:0]   labels_inc;
  logic [dnswe_pkg::PosW-1:0]   pos_inc;
  logic [dnswe_pkg::PosW-1:0]   pos_inc2;
  dnswe_pkg::err_e              err;

  assign is_dot     = (char_i == dnswe_pkg::CharDot);
  assign is_upper   = (char_i >= 8'h41) && (char_i <= 8'h5a);
  assign is_allowed = ((char_i >= 8'h30) && (char_i <= 8'h39)) ||
                      ((char_i >= 8'h61) && (char_i <= 8'h7a)) || is_upper ||
                      (char_i == dnswe_pkg::CharDash) || is_dot ||
                      (char_i == dnswe_pkg::CharStar);
  assign lower_char = is_upper ? (char_i + 8'd32) : char_i;
  assign len_inc    = state_i.label_len + 1'b1;
  assign labels_inc = state_i.labels_done + 1'b1;
  assign pos_inc    = state_i.write_pos + 1'b1;
  assign pos_inc2   = state_i.write_pos + 8'd2;

  // Checks in priority order; ERR_NONE lets the character through.
  always_comb begin
    err = dnswe_pkg::ERR_NONE;
    if (state_i.write_pos > PosLimit) begin
      err = dnswe_pkg::ERR_TOO_LONG;
    end else if (is_dot && (state_i.write_pos == 8'd1)) begin
      err = dnswe_pkg::ERR_LEADING_DOT;
    end else if (!is_allowed) begin
      err = dnswe_pkg::ERR_BAD_CHAR;
    end else if (is_dot && (state_i.label_len == '0)) begin
      err = dnswe_pkg::ERR_EMPTY_LABEL;
    end else if (!is_dot && (len_inc > LenLimit)) begin
      err = dnswe_pkg::ERR_LABEL_LONG;
    end
  end

  always_comb begin
    step_o.next  = state_i;
    step_o.res   = '0;
    step_o.count = 2'd0;
    if (state_i.error_seen) begin
      // Name already failed: swallow characters up to the end of the name.
      if (final_i) begin
        step_o.next = dnswe_pkg::StateFresh;
      end
    end else if (err != dnswe_pkg::ERR_NONE) begin
      step_o.res[0] = make_res('0, '0, 1'b0, err, '0, '0, 1'b1);
      step_o.count  = 2'd1;
      if (final_i) begin
        step_o.next = dnswe_pkg::StateFresh;
      end else begin
        step_o.next.error_seen = 1'b1;
      end
    end else if (is_dot) begin
      step_o.res[0] = make_res(state_i.label_start, {1'b0, state_i.label_len}, 1'b1,
                               dnswe_pkg::ERR_NONE, '0, '0, 1'b0);
      if (final_i) begin
        // A trailing dot closes the name in place of a terminator of its own.
        step_o.res[1] = make_res(state_i.write_pos, '0, 1'b1, dnswe_pkg::ERR_NONE,
                                 pos_inc, labels_inc, 1'b1);
        step_o.count  = 2'd2;
        step_o.next   = dnswe_pkg::StateFresh;
      end else begin
        step_o.count             = 2'd1;
        step_o.next.label_start  = state_i.write_pos;
        step_o.next.label_len    = '0;
        step_o.next.labels_done  = labels_inc;
        step_o.next.write_pos    = pos_inc;
      end
    end else begin
      step_o.res[0] = make_res(state_i.write_pos, lower_char, 1'b1, dnswe_pkg::ERR_NONE,
                               '0, '0, 1'b0);
      if (final_i) begin
        step_o.res[1] = make_res(state_i.label_start, {1'b0, len_inc}, 1'b1,
                                 dnswe_pkg::ERR_NONE, '0, '0, 1'b0);
        step_o.res[2] = make_res(pos_inc, '0, 1'b1, dnswe_pkg::ERR_NONE,
                                 pos_inc2, labels_inc, 1'b1);
        step_o.count  = 2'd3;
        step_o.next   = dnswe_pkg::StateFresh;
      end else begin
        step_o.count          = 2'd1;
        step_o.next.label_len = len_inc;
        step_o.next.write_pos = pos_inc;
      end
    end
  end

endmodule

[hdl/dns_name_wire_encoder_unit.sv]
// Top level of the DNS name wire encoder: name state registers, the
// per-character step and the three-word result register.
// Depends on dnswe_pkg, dnswe_ifs.sv (interfaces) and dnswe_step.
//
// The block turns a dotted domain name, one character per input word, into
// byte writes of the length-prefixed wire format. Label characters are written
// lowercased at their wire position; each dot writes the closed label's length
// at that label's start; the last character adds the last length byte and the
// zero terminator, the final word carrying the total wire length and the
// label count. A single trailing dot is dropped. On an error (name too long,
// leading dot, bad character, empty label, label too long) one word with
// done_res set and the error code is given, the writes already given for the
// name are to be discarded, and the block stays silent until the word that
// carries final_char. A character's words leave from a result register of three
// entries at one word per cycle while out_o.ready is high, and the input is held
// until the last of them leaves (a plain character or a dot gives one word, a
// trailing dot two, a final label character three); characters of a name after
// its error give no words. The next character is accepted in the cycle that the
// last pending word leaves.
module dns_name_wire_encoder_unit #(
  parameter int unsigned NAME_MAX_BYTES  = dnswe_pkg::NameMaxBytesDefault,
  parameter int unsigned LABEL_MAX_BYTES = dnswe_pkg::LabelMaxBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dnswe_char_if.sink        in_i,
  dnswe_wr_if.source        out_o
);

  // Name state: position, label bookkeeping and the error latch.
  dnswe_pkg::state_t state_q;
  dnswe_pkg::state_t state_d;

  // Result register: entry 0 is presented, later entries shift down on a pop.
  dnswe_pkg::res_t [dnswe_pkg::MaxRes-1:0] res_q;
  dnswe_pkg::res_t [dnswe_pkg::MaxRes-1:0] res_d;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;

  dnswe_pkg::step_t step;
  logic             in_fire;
  logic             out_fire;

  dnswe_step #(
    .NAME_MAX_BYTES (NAME_MAX_BYTES),
    .LABEL_MAX_BYTES(LABEL_MAX_BYTES)
  ) u_step (
    .state_i(state_q),
    .char_i (in_i.char_in),
    .final_i(in_i.final_char),
    .step_o (step)
  );

  // A new character is taken once the result register is empty, or will be
  // after the word leaving in this cycle.
  assign out_fire   = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    if (out_fire) begin
      res_d[0] = res_q[1];
      res_d[1] = res_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
    if (in_fire) begin
      state_d = step.next;
      res_d   = step.res;
      cnt_d   = step.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dnswe_pkg::StateFresh;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload needs no reset: it is only seen while cnt_q is nonzero.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.write_addr   = res_q[0].write_addr;
  assign out_o.write_byte   = res_q[0].write_byte;
  assign out_o.write_valid  = res_q[0].write_valid;
  assign out_o.error_code   = res_q[0].error_code;
  assign out_o.total_length = res_q[0].total_length;
  assign out_o.label_count  = res_q[0].label_count;
  assign out_o.done_res     = res_q[0].done_res;

  // The result register holds exactly the words of the last accepted character.
  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (cnt_q == $past(step.count)))
    else $error("result count does not match the accepted character");

  // An error word never carries a buffer write and always ends the name.
  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (res_q[0].error_code != dnswe_pkg::ERR_NONE)) |->
      (!out_o.write_valid && out_o.done_res))
    else $error("error word carries a write or lacks done");

  // A successful name ends on the terminator write with at least one label.
  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.done_res && (res_q[0].error_code == dnswe_pkg::ERR_NONE)) |->
      (out_o.write_valid && (out_o.write_byte == 8'd0) && (out_o.label_count != '0)))
    else $error("final word of a good name is malformed");

  // Nothing is taken while older words other than the leaving one wait.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire)))
    else $error("character accepted over pending words");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for dns_name_wire_encoder_unit: drives dotted names one
// character per word and checks every wire-format write against its own encoder.
// Depends on dnswe_pkg, the handshake interfaces of dnswe_ifs.sv and the unit itself.
module tb_top;

  localparam int unsigned NameMax  = dnswe_pkg::NameMaxBytesDefault;
  localparam int unsigned LabelMax = dnswe_pkg::LabelMaxBytesDefault;

  // The slowest correct run stays far below this: about 400 characters, three
  // words each, every word waiting out a slow receiver, plus sender gaps.
  localparam int unsigned CycleLimit        = 500000;
  localparam int unsigned HoldCycles        = 150;
  localparam int unsigned EndSettleCycles   = 20;
  localparam int unsigned BackpressureItems = 12;
  localparam int unsigned RandomItems       = 30;

  // Receiver stall patterns; a new one is picked at random when the current one runs out.
  typedef enum int {
    SinkFree,
    SinkCoin,
    SinkSlow,
    SinkPeriodic
  } sink_mode_e;

  // Shapes of a random name: mostly well formed, the rest broken on purpose.
  typedef enum int {
    ShapeClean,
    ShapeTrailingDot,
    ShapeLeadingDot,
    ShapeEmptyLabel,
    ShapeBadChar,
    ShapeNoise
  } name_shape_e;

  logic clk;
  logic rst_n;

  dnswe_char_if char_if ();
  dnswe_wr_if   wr_if ();

  dns_name_wire_encoder_unit #(
    .NAME_MAX_BYTES (NameMax),
    .LABEL_MAX_BYTES(LabelMax)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (char_if),
    .out_o (wr_if)
  );

  // Expected writes in the order the unit must give them.
  dnswe_pkg::res_t pending_writes[$];

  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycle_count;
  bit          hold_req;

  // Our copy of the per-name encoder state.
  logic [dnswe_pkg::PosW-1:0] name_pos;
  logic [dnswe_pkg::PosW-1:0] label_head;
  logic [dnswe_pkg::LenW-1:0] label_chars;
  logic [dnswe_pkg::LenW-1:0] labels_closed;
  logic                       name_broken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Encoder prediction
  // ------------------------------------------------------------------------

  function automatic dnswe_pkg::res_t make_word(input logic [dnswe_pkg::PosW-1:0] addr,
                                                input logic [7:0] data,
                                                input logic valid, input dnswe_pkg::err_e err,
                                                input logic [7:0] total,
                                                input logic [dnswe_pkg::LenW-1:0] labels,
                                                input logic done);
    dnswe_pkg::res_t w;
    w.write_addr   = addr;
    w.write_byte   = data;
    w.write_valid  = valid;
    w.error_code   = err;
    w.total_length = total;
    w.label_count  = labels;
    w.done_res     = done;
    return w;
  endfunction

  function automatic void restart_name();
    name_pos      = 8'd1;
    label_head    = 8'd0;
    label_chars   = 7'd0;
    labels_closed = 7'd0;
    name_broken   = 1'b0;
  endfunction

  // An error gives one word with done set and no write. On the last character
  // the encoder starts over at once, otherwise it goes silent until the last one.
  function automatic void report_error(input dnswe_pkg::err_e code, input logic is_last);
    pending_writes.push_back(make_word(8'd0, 8'd0, 1'b0, code, 8'd0, 7'd0, 1'b1));
    if (is_last) begin
      restart_name();
    end else begin
      name_broken = 1'b1;
    end
  endfunction

  // Works out the words one accepted character causes and advances the state.
  function automatic void encode_char(input logic [7:0] c, input logic is_last);
    logic       legal;
    logic [7:0] lowered;
    legal = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
            (c >= 8'h41 && c <= 8'h5a) || c == dnswe_pkg::CharDash ||
            c == dnswe_pkg::CharDot || c == dnswe_pkg::CharStar;
    lowered = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;

    if (name_broken) begin
      if (is_last) restart_name();
      return;
    end
    // The checks run in a fixed order: length of the name first, then a dot at
    // the very start, then the character set, then the label rules.
    if (name_pos > dnswe_pkg::PosW'(NameMax - 2)) begin
      report_error(dnswe_pkg::ERR_TOO_LONG, is_last);
      return;
    end
    if (c == dnswe_pkg::CharDot && name_pos == 8'd1) begin
      report_error(dnswe_pkg::ERR_LEADING_DOT, is_last);
      return;
    end
    if (!legal) begin
      report_error(dnswe_pkg::ERR_BAD_CHAR, is_last);
      return;
    end

    if (c == dnswe_pkg::CharDot) begin
      if (label_chars == 7'd0) begin
        report_error(dnswe_pkg::ERR_EMPTY_LABEL, is_last);
        return;
      end
      pending_writes.push_back(make_word(label_head, {1'b0, label_chars}, 1'b1,
                                         dnswe_pkg::ERR_NONE, 8'd0, 7'd0, 1'b0));
      if (is_last) begin
        // A trailing dot adds nothing but closes the name where it stands.
        pending_writes.push_back(make_word(name_pos, 8'd0, 1'b1, dnswe_pkg::ERR_NONE,
                                           name_pos + 8'd1, labels_closed + 7'd1, 1'b1));
        restart_name();
        return;
      end
      label_head    = name_pos;
      label_chars   = 7'd0;
      labels_closed = labels_closed + 7'd1;
      name_pos      = name_pos + 8'd1;
      return;
    end

    label_chars = label_chars + 7'd1;
    if (label_chars > dnswe_pkg::LenW'(LabelMax)) begin
      report_error(dnswe_pkg::ERR_LABEL_LONG, is_last);
      return;
    end
    pending_writes.push_back(make_word(name_pos, lowered, 1'b1, dnswe_pkg::ERR_NONE,
                                       8'd0, 7'd0, 1'b0));
    if (is_last) begin
      // Close the last label, then the zero terminator with the summary.
      pending_writes.push_back(make_word(label_head, {1'b0, label_chars}, 1'b1,
                                         dnswe_pkg::ERR_NONE, 8'd0, 7'd0, 1'b0));
      pending_writes.push_back(make_word(name_pos + 8'd1, 8'd0, 1'b1, dnswe_pkg::ERR_NONE,
                                         name_pos + 8'd2, labels_closed + 7'd1, 1'b1));
      restart_name();
      return;
    end
    name_pos = name_pos + 8'd1;
  endfunction

  // ------------------------------------------------------------------------
  // Sender side
  // ------------------------------------------------------------------------

  // Offers one character and returns at the edge that accepts it. The sender
  // works in bursts; between bursts valid may drop for a random gap.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    char_if.valid      <= 1'b1;
    char_if.char_in    <= c;
    char_if.final_char <= is_last;
    encode_char(c, is_last);
    do @(posedge clk); while (!char_if.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_queue(ref logic [7:0] chars[$]);
    for (int i = 0; i < chars.size(); i++) begin
      send_char(chars[i], i == chars.size() - 1);
    end
  endtask

  // Sender pause: nothing is offered until every expected word has come.
  task automatic wait_for_writes();
    char_if.valid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
    burst_left = 0;
  endtask

  function automatic logic [7:0] pick_label_char();
    int unsigned r;
    r = $urandom_range(0, 37);
    if (r < 26) return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(r);
    if (r < 36) return 8'h30 + 8'(r - 26);
    if (r == 36) return dnswe_pkg::CharDash;
    return dnswe_pkg::CharStar;
  endfunction

  // A name of n_chars characters with a dot after every run of run_len label
  // characters; with dot_at_end the last character is a dot.
  task automatic send_dotted_run(input int n_chars, input int run_len, input bit dot_at_end);
    logic [7:0] chars[$];
    for (int i = 0; i < n_chars; i++) begin
      if ((i % (run_len + 1)) == run_len || (dot_at_end && i == n_chars - 1)) begin
        chars.push_back(dnswe_pkg::CharDot);
      end else begin
        chars.push_back(pick_label_char());
      end
    end
    send_queue(chars);
  endtask

  task automatic send_random_name(input bit clean_only);
    logic [7:0]  chars[$];
    name_shape_e shape;
    int unsigned pick;
    int unsigned n_labels;
    int unsigned len;
    int unsigned p;
    pick = clean_only ? 0 : $urandom_range(0, 14);
    if (pick <= 8)       shape = ShapeClean;
    else if (pick <= 10) shape = ShapeTrailingDot;
    else if (pick == 11) shape = ShapeLeadingDot;
    else if (pick == 12) shape = ShapeEmptyLabel;
    else if (pick == 13) shape = ShapeBadChar;
    else                 shape = ShapeNoise;

    n_labels = $urandom_range(1, 4);
    for (int l = 0; l < n_labels; l++) begin
      len = $urandom_range(1, 7);
      for (int k = 0; k < len; k++) chars.push_back(pick_label_char());
      if (l != n_labels - 1) chars.push_back(dnswe_pkg::CharDot);
    end

    case (shape)
      ShapeTrailingDot: chars.push_back(dnswe_pkg::CharDot);
      ShapeLeadingDot:  chars.push_front(dnswe_pkg::CharDot);
      ShapeEmptyLabel: begin
        p = $urandom_range(1, chars.size());
        chars.insert(p, dnswe_pkg::CharDot);
        chars.insert(p, dnswe_pkg::CharDot);
      end
      ShapeBadChar: chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      ShapeNoise: begin
        chars.delete();
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          chars.push_back(($urandom_range(0, 3) == 0) ? dnswe_pkg::CharDot
                                                      : 8'($urandom_range(0, 255)));
        end
      end
      default: ;
    endcase
    send_queue(chars);
  endtask

  // ------------------------------------------------------------------------
  // Receiver side: its own stall pattern, plus a long hold-off on request.
  // ------------------------------------------------------------------------

  initial begin : write_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode      = SinkFree;
    mode_left = 0;
    hold_left = 0;
    wr_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        wr_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          SinkFree:  wr_if.ready <= 1'b1;
          SinkCoin:  wr_if.ready <= 1'($urandom_range(0, 1));
          SinkSlow:  wr_if.ready <= ($urandom_range(0, 3) == 0);
          default:   wr_if.ready <= ((mode_left % 5) != 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_writes
    dnswe_pkg::res_t want;
    if (rst_n && wr_if.valid && wr_if.ready) begin
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: word with nothing expected, expected none, actual addr %0d data %0d",
                 $time, wr_if.write_addr, wr_if.write_byte);
      end else begin
        want = pending_writes.pop_front();
        compare_field("write_addr", want.write_addr, wr_if.write_addr);
        compare_field("write_byte", want.write_byte, wr_if.write_byte);
        compare_field("write_valid", want.write_valid, wr_if.write_valid);
        compare_field("error_code", want.error_code, wr_if.error_code);
        compare_field("total_length", want.total_length, wr_if.total_length);
        compare_field("label_count", want.label_count, wr_if.label_count);
        compare_field("done_res", want.done_res, wr_if.done_res);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Short names touching every character class and every error rule but the length limits.
  task automatic test_directed_names();
    send_text("a");
    send_text("AZaz09-*");
    send_text("ab.");
    send_text(".");
    send_text(".ab");
    send_text("a..b");
    send_text("a..");
    send_char(8'hff, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h62, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h80, 1'b1);
    wait_for_writes();
  endtask

  // A single label one character over the limit, caught on the last character.
  task automatic test_label_limit();
    send_dotted_run(LabelMax + 1, LabelMax + 1, 1'b0);
    wait_for_writes();
  endtask

  // A name made of labels at the length limit that runs one character past the
  // longest legal name, so the length error lands on its last character.
  task automatic test_name_limit();
    send_dotted_run(NameMax - 1, LabelMax, 1'b0);
    wait_for_writes();
  endtask

  // The receiver holds off long enough that the result register fills and the
  // unit has to stall its input while the sender keeps offering.
  task automatic test_output_backpressure();
    int unsigned start;
    start    = items_sent;
    hold_req = 1'b1;
    while (items_sent - start < BackpressureItems) send_random_name(1'b1);
    wait_for_writes();
  endtask

  task automatic test_random_names();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < RandomItems) send_random_name(1'b0);
    wait_for_writes();
  endtask

  initial begin
    rst_n              = 1'b0;
    char_if.valid      <= 1'b0;
    char_if.char_in    <= 8'd0;
    char_if.final_char <= 1'b0;
    hold_req           = 1'b0;
    mismatch_count     = 0;
    items_sent         = 0;
    burst_left         = 0;
    cycle_count        = 0;
    restart_name();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_names();
    test_label_limit();
    test_name_limit();
    test_output_backpressure();
    test_random_names();

    // Characters of a broken name give no words, so let the unit settle.
    repeat (EndSettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
